// ===== rtl/sglf_pkg.sv =====
// Shared types and constants of the separable Gaussian line filter.
package sglf_pkg;

  localparam int unsigned LineMax = 256;
  localparam int unsigned AddrW   = $clog2(LineMax);
  localparam int unsigned CntW    = AddrW + 1;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned ProdW   = SampleW + CoefW;
  localparam int unsigned AccW    = ProdW + 3;
  localparam int unsigned TsumW   = CoefW + 3;
  localparam int unsigned NumW    = AccW + 1;
  localparam int unsigned RemW    = NumW - SampleW;
  localparam int unsigned PosW    = CntW + 2;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned MaxOut  = 4;

  typedef enum logic [IdxW-1:0] {
    REG_LINE_LENGTH = 3'd0,
    REG_RADIUS      = 3'd1,
    REG_MODE        = 3'd2,
    REG_COEF_CENTER = 3'd3,
    REG_COEF_ONE    = 3'd4,
    REG_COEF_TWO    = 3'd5,
    REG_COEF_THREE  = 3'd6
  } sglf_reg_e;

  typedef enum logic [1:0] {
    MODE_CROP   = 2'd0,
    MODE_ZERO   = 2'd1,
    MODE_REPEAT = 2'd2,
    MODE_MIRROR = 2'd3
  } sglf_mode_e;

  typedef struct packed {
    logic [CntW-1:0]             line_length;
    logic [1:0]                  radius;
    logic [1:0]                  mode;
    logic [3:0][CoefW-1:0]       coef;
  } sglf_cfg_t;

  typedef struct packed {
    logic                   wr_en;
    logic                   acc_clr;
    logic                   rd_en;
    logic                   mul_en;
    logic                   acc_en;
    logic                   div_start;
    logic                   div_step;
    logic                   out_load;
    logic                   line_end;
    logic [CntW-1:0]        n;
    logic [CntW-1:0]        pos;
    logic signed [2:0]      tap;
  } sglf_cmd_t;

  typedef struct packed {
    logic out_busy;
  } sglf_sts_t;

endpackage

// ===== rtl/separable_gaussian_line_filter_core.sv =====
// Top level of the separable Gaussian line filter (one 1-D pass).
// Intake: a sample word is taken from idle, and outputs are decided on in the cycle after.
// Each output walks 2*radius+1 taps, each through memory read, multiply and accumulate,
// then the restoring divider (init and run states) and the output state, which waits on backpressure.
// A sample causes one output mid-line (more after radius is lowered), up to four at line end.
// Reset (async, active low) clears counters, control, config registers and output valid; line memory is not cleared.
module separable_gaussian_line_filter_core
  import sglf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write port
  input  logic                cfg_we_i,
  input  logic [IdxW-1:0]     cfg_idx_i,
  input  logic [CoefW-1:0]    cfg_wdata_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // [15:0] sample
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // [15:0] smoothed
  output logic                m_axis_tlast    // line_end
);

  sglf_cfg_t cfg;
  sglf_cmd_t cmd;
  sglf_sts_t sts;

  // Hold the register set.
  sglf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // Sequence each word through store, tap walk, divide and output.
  sglf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Memory, arithmetic and the output register.
  sglf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .smoothed_o  (m_axis_tdata),
    .line_end_o  (m_axis_tlast)
  );

  // Never overwrite a word still waiting at the output.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output word overwritten");

  // Take no sample while accumulating, dividing or loading the output.
  a_idle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !(cmd.div_step || cmd.acc_en || cmd.out_load))
    else $error("sample taken while busy");

  // A sample write is followed by the decision cycle, never a write again.
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_en |=> !s_axis_tready)
    else $error("back-to-back sample writes");

endmodule

// ===== rtl/sglf_cfg.sv =====
// Configuration register file of the line filter.
module sglf_cfg
  import sglf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [IdxW-1:0]     idx_i,
  input  logic [CoefW-1:0]    wdata_i,
  output sglf_cfg_t           cfg_o
);

  sglf_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_length <= CntW'(LineMax);
      cfg_q.radius      <= 2'd1;
      cfg_q.mode        <= MODE_CROP;
      cfg_q.coef[0]     <= CoefW'(32768);
      cfg_q.coef[1]     <= CoefW'(16384);
      cfg_q.coef[2]     <= '0;
      cfg_q.coef[3]     <= '0;
    end else if (we_i) begin
      unique case (idx_i)
        REG_LINE_LENGTH: cfg_q.line_length <= wdata_i[CntW-1:0];
        REG_RADIUS:      cfg_q.radius      <= wdata_i[1:0];
        REG_MODE:        cfg_q.mode        <= wdata_i[1:0];
        REG_COEF_CENTER: cfg_q.coef[0]     <= wdata_i;
        REG_COEF_ONE:    cfg_q.coef[1]     <= wdata_i;
        REG_COEF_TWO:    cfg_q.coef[2]     <= wdata_i;
        REG_COEF_THREE:  cfg_q.coef[3]     <= wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/sglf_ctrl.sv =====
// Sequencing state machine: sample intake, tap walk, divide and output.
module sglf_ctrl
  import sglf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sglf_cfg_t  cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  sglf_sts_t  sts_i,
  output sglf_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_TAP_RD, ST_TAP_MUL, ST_TAP_ACC, ST_DIV_INIT, ST_DIV_RUN, ST_OUT
  } state_e;

  state_e                 state_q;
  logic [CntW-1:0]        st_q, og_q;
  logic signed [2:0]      tap_q;
  logic [2:0]             cnt_q;
  logic                   last_q;
  logic [3:0]             dcnt_q;

  logic [CntW-1:0] len_eff;
  logic [CntW-1:0] st_inc;
  logic [CntW:0]   og_plus_r;
  logic            emit;
  logic signed [2:0] r_s;

  always_comb begin
    len_eff = cfg_i.line_length;
    if (len_eff == '0) len_eff = CntW'(1);
    if (len_eff > CntW'(LineMax)) len_eff = CntW'(LineMax);
  end

  assign st_inc    = st_q + CntW'(1);
  assign og_plus_r = {1'b0, og_q} + (CntW+1)'(cfg_i.radius);
  assign r_s       = signed'({1'b0, cfg_i.radius});
  assign emit      = (og_q < st_q) && (last_q || (og_plus_r < {1'b0, st_q}))
                     && (cnt_q < 3'(MaxOut));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      st_q    <= '0;
      og_q    <= '0;
      tap_q   <= '0;
      cnt_q   <= '0;
      last_q  <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            st_q    <= st_inc;
            last_q  <= st_inc >= len_eff;
            cnt_q   <= '0;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (emit) begin
            tap_q   <= -r_s;
            state_q <= ST_TAP_RD;
          end else begin
            if (last_q) begin
              st_q <= '0;
              og_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_TAP_RD:  state_q <= ST_TAP_MUL;
        ST_TAP_MUL: state_q <= ST_TAP_ACC;
        ST_TAP_ACC: begin
          if (tap_q == r_s) begin
            state_q <= ST_DIV_INIT;
          end else begin
            tap_q   <= tap_q + 3'sd1;
            state_q <= ST_TAP_RD;
          end
        end
        ST_DIV_INIT: begin
          dcnt_q  <= '0;
          state_q <= ST_DIV_RUN;
        end
        ST_DIV_RUN: begin
          dcnt_q <= dcnt_q + 4'd1;
          if (dcnt_q == 4'd15) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!sts_i.out_busy) begin
            og_q    <= og_q + CntW'(1);
            cnt_q   <= cnt_q + 3'd1;
            state_q <= ST_CHECK;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.n         = st_q;
    cmd_o.pos       = og_q;
    cmd_o.tap       = tap_q;
    cmd_o.line_end  = last_q && (og_q + CntW'(1) == st_q);
    cmd_o.wr_en     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.acc_clr   = (state_q == ST_CHECK);
    cmd_o.rd_en     = (state_q == ST_TAP_RD);
    cmd_o.mul_en    = (state_q == ST_TAP_MUL);
    cmd_o.acc_en    = (state_q == ST_TAP_ACC);
    cmd_o.div_start = (state_q == ST_DIV_INIT);
    cmd_o.div_step  = (state_q == ST_DIV_RUN);
    cmd_o.out_load  = (state_q == ST_OUT) && !sts_i.out_busy;
  end

endmodule

// ===== rtl/sglf_dp.sv =====
// Datapath: line memory, boundary tap resolution, multiply-accumulate, divider, output register.
module sglf_dp
  import sglf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sglf_cfg_t           cfg_i,
  input  sglf_cmd_t           cmd_i,
  output sglf_sts_t           sts_o,
  input  logic [SampleW-1:0]  sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SampleW-1:0]  smoothed_o,
  output logic                line_end_o
);

  logic [SampleW-1:0] mem [LineMax];

  logic signed [PosW-1:0] j, n_s, p, pc;
  logic                   inr, use_c, zero_c;
  logic [1:0]             tap_dist;

  logic [SampleW-1:0] rdata_q;
  logic               use_q, zero_q, use2_q;
  logic [CoefW-1:0]   w_q, w2_q;
  logic [ProdW-1:0]   prod_q;
  logic [AccW-1:0]    acc_q;
  logic [TsumW-1:0]   tsum_q;
  logic [RemW-1:0]    rem_q;
  logic [SampleW-1:0] nlow_q, quo_q;
  logic               sat_q, zdiv_q;
  logic [NumW-1:0]    num;
  logic [RemW:0]      trial;
  logic               out_valid_q, line_end_q;
  logic [SampleW-1:0] smoothed_q;

  assign j        = signed'({2'b00, cmd_i.pos}) + PosW'(cmd_i.tap);
  assign n_s      = signed'({2'b00, cmd_i.n});
  assign inr      = (j >= 0) && (j < n_s);
  assign tap_dist = cmd_i.tap[2] ? 2'(-cmd_i.tap) : cmd_i.tap[1:0];

  // Resolve the tap position and whether its weight counts.
  always_comb begin
    use_c  = 1'b1;
    zero_c = 1'b0;
    p      = j;
    case (cfg_i.mode)
      MODE_CROP:   use_c = inr;
      MODE_ZERO:   zero_c = !inr;
      MODE_MIRROR: begin
        if (j < 0)          p = -j - PosW'(1);
        else if (j >= n_s)  p = (n_s <<< 1) - j - PosW'(1);
      end
      default: ;
    endcase
    if (p < 0)                 pc = '0;
    else if (p > n_s - 1)      pc = n_s - PosW'(1);
    else                       pc = p;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[cmd_i.n[AddrW-1:0]] <= sample_i;
    if (cmd_i.rd_en) begin
      rdata_q <= mem[pc[AddrW-1:0]];
      use_q   <= use_c;
      zero_q  <= zero_c;
      w_q     <= cfg_i.coef[tap_dist];
    end
    if (cmd_i.mul_en) begin
      prod_q <= zero_q ? '0 : (ProdW'(w_q) * ProdW'(rdata_q));
      use2_q <= use_q;
      w2_q   <= w_q;
    end
  end

  assign num   = NumW'(acc_q) + NumW'(tsum_q >> 1);
  assign trial = {rem_q, nlow_q[SampleW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q  <= '0;
      tsum_q <= '0;
    end else if (cmd_i.acc_en && use2_q) begin
      acc_q  <= acc_q + AccW'(prod_q);
      tsum_q <= tsum_q + TsumW'(w2_q);
    end
    if (cmd_i.div_start) begin
      zdiv_q <= (tsum_q == '0);
      sat_q  <= num >= {1'b0, tsum_q, {SampleW{1'b0}}};
      rem_q  <= num[NumW-1:SampleW];
      nlow_q <= num[SampleW-1:0];
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      nlow_q <= nlow_q << 1;
      if (trial >= (RemW+1)'(tsum_q)) begin
        rem_q <= RemW'(trial - (RemW+1)'(tsum_q));
        quo_q <= {quo_q[SampleW-2:0], 1'b1};
      end else begin
        rem_q <= trial[RemW-1:0];
        quo_q <= {quo_q[SampleW-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      smoothed_q <= zdiv_q ? '0 : (sat_q ? '1 : quo_q);
      line_end_q <= cmd_i.line_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign smoothed_o     = smoothed_q;
  assign line_end_o     = line_end_q;

endmodule

// ===== tb/separable_gaussian_line_filter_core_test.sv =====
// Self-checking testbench of the separable Gaussian line filter core.
`timescale 1ns / 1ps

module separable_gaussian_line_filter_core_test;
  import sglf_pkg::*;

  // index with no register behind it; writes to it must be ignored
  localparam logic [IdxW-1:0] RegUnused = 3'd7;
  // settle time after draining; covers up to four outputs at a line end at the widest radius
  localparam int unsigned SettleCycles = 250;

  typedef struct packed {
    logic [15:0] smoothed;
    logic        line_end;
  } smooth_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IdxW-1:0] cfg_idx_i = '0;
  logic [CoefW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic m_axis_tlast;

  separable_gaussian_line_filter_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  // shadow registers and line state of the filter
  logic [8:0] sh_len;
  logic [1:0] sh_radius;
  sglf_mode_e sh_mode;
  logic [15:0] sh_coef [4];
  logic [15:0] line_mem [LineMax];
  int unsigned taken_cnt;
  int unsigned given_cnt;

  smooth_word_t expected_q[$];
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned mismatches;
  bit no_stall;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Smoothed value at position pos of a line holding n samples.
  function automatic logic [15:0] smooth_at(int pos, int n);
    longint unsigned acc;
    longint unsigned tsum;
    longint unsigned q;
    int j;
    int r;
    bit take;
    logic [15:0] v;
    acc = 0;
    tsum = 0;
    r = sh_radius;
    for (int k = -r; k <= r; k++) begin
      j = pos + k;
      take = 1'b1;
      v = '0;
      if (j >= 0 && j < n) begin
        v = line_mem[j];
      end else begin
        case (sh_mode)
          MODE_CROP: take = 1'b0;
          MODE_ZERO: v = '0;
          MODE_REPEAT: v = line_mem[(j < 0) ? 0 : n - 1];
          default: begin
            j = (j < 0) ? -j - 1 : 2 * n - j - 1;
            if (j < 0) j = 0;
            if (j > n - 1) j = n - 1;
            v = line_mem[j];
          end
        endcase
      end
      if (take) begin
        acc += longint'(sh_coef[(k < 0) ? -k : k]) * longint'(v);
        tsum += sh_coef[(k < 0) ? -k : k];
      end
    end
    if (tsum == 0) return '0;
    q = (acc + tsum / 2) / tsum;
    if (q > 65535) q = 65535;
    return q[15:0];
  endfunction

  // Store one accepted sample and queue the outputs it releases.
  function automatic void take_sample(logic [15:0] smp);
    int unsigned len;
    bit last;
    int cnt;
    smooth_word_t w;
    len = (sh_len == 0) ? 1 : ((sh_len > LineMax) ? LineMax : sh_len);
    line_mem[taken_cnt % LineMax] = smp;
    taken_cnt++;
    last = taken_cnt >= len;
    cnt = 0;
    while (given_cnt < taken_cnt && (last || given_cnt + sh_radius < taken_cnt) && cnt < 4) begin
      w.smoothed = smooth_at(given_cnt, taken_cnt);
      w.line_end = last && (given_cnt + 1 == taken_cnt);
      expected_q.push_back(w);
      given_cnt++;
      cnt++;
    end
    if (last) begin
      taken_cnt = 0;
      given_cnt = 0;
    end
  endfunction

  // Short gaps mostly, a long one now and then.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // Send one sample word and hold until the block takes it.
  task automatic send_sample(logic [15:0] smp);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= smp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    take_sample(smp);
    words_sent++;
    gap = no_stall ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off until every expected word is back and the core has gone quiet.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all registers plus the unused index; call only while idle.
  task automatic set_config(logic [8:0] len, logic [1:0] r, sglf_mode_e mode,
                            logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
                            logic [15:0] c3);
    logic [15:0] vals [8];
    vals[REG_LINE_LENGTH] = {7'd0, len};
    vals[REG_RADIUS] = {14'd0, r};
    vals[REG_MODE] = {14'd0, mode};
    vals[REG_COEF_CENTER] = c0;
    vals[REG_COEF_ONE] = c1;
    vals[REG_COEF_TWO] = c2;
    vals[REG_COEF_THREE] = c3;
    vals[RegUnused] = 16'($urandom());
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= i[IdxW-1:0];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    sh_len = len;
    sh_radius = r;
    sh_mode = mode;
    sh_coef[0] = c0;
    sh_coef[1] = c1;
    sh_coef[2] = c2;
    sh_coef[3] = c3;
  endtask

  // Output side: random backpressure unless a no-stall stretch is on.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (!no_stall && stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Compare every accepted output word with the oldest expectation.
  always @(posedge clk_i) begin
    smooth_word_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: smoothed %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        w = expected_q.pop_front();
        if (w.smoothed !== m_axis_tdata || w.line_end !== m_axis_tlast) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected smoothed %h last %b, got %h last %b",
                     w.smoothed, w.line_end, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  // Every boundary mode at the widest kernel over a short line with extreme samples.
  task automatic test_boundary_modes();
    for (int m = 0; m < 4; m++) begin
      set_config(9'd4, 2'd3, sglf_mode_e'(m), 16'hFFFF, 16'h8000, 16'h4000, 16'h0001);
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'h1234);
      send_sample(16'hEDCB);
      drain();
    end
  endtask

  // Lines of one and two samples, and length zero acting as one.
  task automatic test_short_lines();
    set_config(9'd1, 2'd3, MODE_MIRROR, 16'd100, 16'd200, 16'd300, 16'd400);
    send_sample(16'hA5A5);
    drain();
    set_config(9'd2, 2'd3, MODE_REPEAT, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    send_sample(16'h5A5A);
    send_sample(16'hFFFF);
    drain();
    set_config(9'd0, 2'd0, MODE_ZERO, 16'h8000, 16'd0, 16'd0, 16'd0);
    send_sample(16'h7FFF);
    drain();
  endtask

  // All weights zero: every output must be zero.
  task automatic test_zero_weights();
    set_config(9'd2, 2'd1, MODE_CROP, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    drain();
  endtask

  // Shorten the line after three samples; the next sample closes it.
  task automatic test_midline_shorten();
    set_config(9'd8, 2'd1, MODE_MIRROR, 16'h8000, 16'h4000, 16'd0, 16'd0);
    send_sample(16'h1111);
    send_sample(16'h2222);
    send_sample(16'h3333);
    drain();
    set_config(9'd2, 2'd2, MODE_REPEAT, 16'h6000, 16'h3000, 16'h1000, 16'd0);
    send_sample(16'h4444);
    drain();
  endtask

  // Random settings and lines, mostly short, one full length at most.
  task automatic test_random_lines();
    logic [8:0] len;
    logic [15:0] c [4];
    int long_lines;
    int nlines;
    int eff;
    long_lines = 0;
    while (words_sent < 400) begin
      case ($urandom_range(0, 19))
        0: len = 9'd256;
        1: len = 9'd511;
        2: len = 9'd0;
        default: len = 9'($urandom_range(1, 12));
      endcase
      if ((len == 0 || len > 12) && (long_lines >= 1 || words_sent > 150))
        len = 9'($urandom_range(1, 12));
      if (len == 0 || len > 12) long_lines++;
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 5))
          0: c[i] = 16'h0000;
          1: c[i] = 16'hFFFF;
          default: c[i] = 16'($urandom());
        endcase
      end
      no_stall = ($urandom_range(0, 4) == 0);
      set_config(len, 2'($urandom_range(0, 3)), sglf_mode_e'($urandom_range(0, 3)),
                 c[0], c[1], c[2], c[3]);
      eff = (len == 0) ? 1 : ((len > LineMax) ? LineMax : len);
      nlines = (eff > 12) ? 1 : $urandom_range(1, 4);
      for (int l = 0; l < nlines; l++) begin
        for (int s = 0; s < eff; s++) begin
          // now and then pause until the output side has caught up
          if ($urandom_range(0, 39) == 0) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk_i);
            while (expected_q.size() != 0) @(posedge clk_i);
          end
          send_sample(16'($urandom()));
        end
      end
      drain();
    end
    no_stall = 1'b0;
  endtask

  initial begin
    words_sent = 0;
    words_checked = 0;
    mismatches = 0;
    no_stall = 1'b0;
    taken_cnt = 0;
    given_cnt = 0;
    sh_len = 9'd256;
    sh_radius = 2'd1;
    sh_mode = MODE_CROP;
    sh_coef[0] = 16'd32768;
    sh_coef[1] = 16'd16384;
    sh_coef[2] = 16'd0;
    sh_coef[3] = 16'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_boundary_modes();
    test_short_lines();
    test_zero_weights();
    test_midline_shorten();
    test_random_lines();
    drain();
    $display("Covered all four boundary modes, radius 0..3, line lengths 0..511 and weight extremes.");
    $display("Sent %0d samples, checked %0d output words, %0d mismatches.",
             words_sent, words_checked, mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== separable_gaussian_line_filter_core.f =====
rtl/sglf_pkg.sv
rtl/sglf_cfg.sv
rtl/sglf_ctrl.sv
rtl/sglf_dp.sv
rtl/separable_gaussian_line_filter_core.sv
tb/separable_gaussian_line_filter_core_test.sv
